// ===== sv/plm_pkg.sv =====
`default_nettype none
package plm_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int SIZE_W        = 9;
  localparam int IDX_W         = 8;
  localparam int COMP_W        = 8;
  localparam int ARGB_W        = 32;
  localparam int DIST_W        = 18;

  localparam logic [COMP_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [SIZE_W-1:0] SIZE_RESET   = 9'd256;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_CONVERT = 2'd1,
    ACT_MATCH   = 2'd2
  } action_t;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_RANGE = 1'b1
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic              clear;
    logic              issue;
    logic [ADDR_W-1:0] idx;
  } scan_ctl_t;

endpackage
`default_nettype wire

// ===== sv/plm_ram.sv =====
`default_nettype none
module plm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/plm_match.sv =====
`default_nettype none
module plm_match
  import plm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire scan_ctl_t         ctl,
  input  wire rgb_t              rd_entry,
  input  wire rgb_t              target,
  output      logic              pipe_busy,
  output      logic [ADDR_W-1:0] best_idx
);

  logic              p1_vld;
  logic [ADDR_W-1:0] p1_idx;
  logic              p2_vld;
  logic [ADDR_W-1:0] p2_idx;
  logic [DIST_W-1:0] p2_dist;
  logic              have;
  logic [DIST_W-1:0] best_dist;
  logic [DIST_W-1:0] cur_dist;

  function automatic logic [2*COMP_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                                  input logic [COMP_W-1:0] b);
    logic [COMP_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {{COMP_W{1'b0}}, d} * {{COMP_W{1'b0}}, d};
  endfunction

  always_comb begin
    cur_dist = DIST_W'(sq_diff(rd_entry.red, target.red))
             + DIST_W'(sq_diff(rd_entry.green, target.green))
             + DIST_W'(sq_diff(rd_entry.blue, target.blue));
  end

  assign pipe_busy = p1_vld | p2_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld   <= 1'b0;
      p2_vld   <= 1'b0;
      have     <= 1'b0;
      best_idx <= '0;
    end else begin
      p1_vld <= ctl.issue;
      p2_vld <= p1_vld;
      if (ctl.clear) begin
        have     <= 1'b0;
        best_idx <= '0;
      end else if (p2_vld && (!have || p2_dist < best_dist)) begin
        have      <= 1'b1;
        best_idx  <= p2_idx;
        best_dist <= p2_dist;
      end
    end
    p1_idx  <= ctl.idx;
    p2_idx  <= p1_idx;
    p2_dist <= cur_dist;
  end

endmodule
`default_nettype wire

// ===== sv/palette_lookup_and_match.sv =====
// Palette lookup and nearest-color match engine, 256 x 24-bit RGB entries.
// Command channel: an item (action, entry_index, red, green, blue) is taken
// at a clock edge with start high and busy low. Each item gives one result,
// shown for one cycle with done high; the receiver cannot stall it.
// Write, convert and the unused action: result in the cycle after the
// transaction, and a new item can follow every cycle. The palette RAM read
// is issued on the accept edge and its registered data feeds the result.
// Match: walks the n entries in use through the one read port of the RAM,
// one per cycle, then a two-stage distance and compare pipe. The result is
// shown once the walk and the pipe are empty; busy stays high until it has
// been shown, and only then is the next item taken.
// The user must write palette_size through cfg_we/cfg_data only while the
// block is idle; the block itself does not enforce this.
// Reset: palette_size returns to 256 and a valid bit per entry is cleared
// at once, so every entry reads as opaque black until written; no sweep.
`default_nettype none
module palette_lookup_and_match
  import plm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic [1:0]        action,
  input  wire logic [IDX_W-1:0]  entry_index,
  input  wire logic [COMP_W-1:0] red,
  input  wire logic [COMP_W-1:0] green,
  input  wire logic [COMP_W-1:0] blue,
  input  wire logic              cfg_we,
  input  wire logic [SIZE_W-1:0] cfg_data,
  output      logic              done,
  output      logic              status,
  output      logic [ARGB_W-1:0] argb_pixel,
  output      logic [IDX_W-1:0]  match_index
);

  state_t               state;
  state_t               state_next;
  logic [SIZE_W-1:0]    palette_size;
  logic [SIZE_W-1:0]    n_eff;
  logic [CNT_W-1:0]     ptr;
  rgb_t                 tgt;
  logic                 s1_valid;
  logic [1:0]           s1_action;
  logic                 s1_status;
  logic                 s1_inrange;
  logic [PALETTE_DEPTH-1:0] vld;
  logic                 vld_q;
  logic                 accept;
  logic                 in_range;
  logic                 wr_en;
  logic                 issue;
  logic                 pipe_busy;
  logic [ADDR_W-1:0]    raddr;
  logic [ADDR_W-1:0]    waddr;
  rgb_t                 wdata;
  rgb_t                 rdata;
  rgb_t                 rd_entry;
  scan_ctl_t            ctl;
  logic [ADDR_W-1:0]    best_idx;

  assign n_eff    = (palette_size > SIZE_W'(PALETTE_DEPTH)) ? SIZE_W'(PALETTE_DEPTH)
                                                           : palette_size;
  assign accept   = start && !busy;
  assign in_range = {1'b0, entry_index} < n_eff;
  assign wr_en    = accept && (action == ACT_WRITE) && in_range;
  assign issue    = (state == ST_SCAN) && (SIZE_W'(ptr) < n_eff);
  assign waddr    = entry_index[ADDR_W-1:0];
  assign wdata    = '{red: red, green: green, blue: blue};
  assign raddr    = (state == ST_SCAN) ? ptr[ADDR_W-1:0] : entry_index[ADDR_W-1:0];
  assign rd_entry = vld_q ? rdata : '0;

  plm_ram #(
    .WIDTH ($bits(rgb_t)),
    .DEPTH (PALETTE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  plm_match u_match (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .rd_entry  (rd_entry),
    .target    (tgt),
    .pipe_busy (pipe_busy),
    .best_idx  (best_idx)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && action == ACT_MATCH) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue && !pipe_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    ctl.clear = 1'b0;
    ctl.issue = 1'b0;
    ctl.idx   = ptr[ADDR_W-1:0];
    unique case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        ctl.clear = start && (action == ACT_MATCH);
      end
      ST_SCAN: ctl.issue = issue;
      ST_DONE: busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      palette_size <= SIZE_RESET;
      s1_valid     <= 1'b0;
      vld          <= '0;
      ptr          <= '0;
    end else begin
      state    <= state_next;
      s1_valid <= accept && (action != ACT_MATCH);
      if (cfg_we) begin
        palette_size <= cfg_data;
      end
      if (wr_en) begin
        vld[waddr] <= 1'b1;
      end
      if (accept && action == ACT_MATCH) begin
        ptr <= '0;
      end else if (issue) begin
        ptr <= ptr + CNT_W'(1);
      end
    end
    vld_q <= vld[raddr];
    if (accept) begin
      tgt        <= wdata;
      s1_action  <= action;
      s1_inrange <= in_range;
      s1_status  <= (action == ACT_WRITE && !in_range) ? STATUS_RANGE : STATUS_OK;
    end
  end

  always_comb begin
    done        = 1'b0;
    status      = STATUS_OK;
    argb_pixel  = '0;
    match_index = '0;
    if (state == ST_DONE) begin
      done        = 1'b1;
      match_index = IDX_W'(best_idx);
    end else if (s1_valid) begin
      done   = 1'b1;
      status = s1_status;
      if (s1_action == ACT_CONVERT) begin
        argb_pixel = s1_inrange ? {ALPHA_OPAQUE, rd_entry} : {ALPHA_OPAQUE, 24'h0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/plm_checker.sv =====
`default_nettype none
module plm_checker
  import plm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [1:0]        action,
  input wire logic              done,
  input wire logic              status,
  input wire logic [ARGB_W-1:0] argb_pixel,
  input wire logic [IDX_W-1:0]  match_index
);

  // short transactions answer in the next cycle
  a_short_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action != ACT_MATCH) |=> done)
    else $error("write/convert result missing");

  a_match_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_MATCH) |=> (busy && !done))
    else $error("match did not hold busy");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    !done |-> (status == STATUS_OK && argb_pixel == '0 && match_index == '0))
    else $error("result fields driven without done");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    (done && argb_pixel != '0) |-> (argb_pixel[31:24] == ALPHA_OPAQUE && status == STATUS_OK))
    else $error("converted pixel without opaque alpha");

  a_reset: assert property (@(posedge clk)
    rst |=> (!done && !busy))
    else $error("activity right after reset");

endmodule

bind palette_lookup_and_match plm_checker u_plm_checker (.*);
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import plm_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int MAX_PRINTS  = 100;

  typedef struct packed {
    logic              status;
    logic [ARGB_W-1:0] argb;
    logic [IDX_W-1:0]  idx;
  } px_result_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        action;
  logic [IDX_W-1:0]  entry_index;
  logic [COMP_W-1:0] red;
  logic [COMP_W-1:0] green;
  logic [COMP_W-1:0] blue;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_data;
  logic              done;
  logic              status;
  logic [ARGB_W-1:0] argb_pixel;
  logic [IDX_W-1:0]  match_index;

  logic [23:0]       pal_mirror [PALETTE_DEPTH];
  logic [SIZE_W-1:0] pal_size_mirror;
  px_result_t        pending_px [$];
  int                err_count;
  int                result_count;
  int                cycle_count;
  bit                no_idle;

  palette_lookup_and_match u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .entry_index(entry_index),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .done       (done),
    .status     (status),
    .argb_pixel (argb_pixel),
    .match_index(match_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_size();
    return (pal_size_mirror > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(pal_size_mirror);
  endfunction

  function automatic px_result_t predict_pixel(logic [1:0] act, logic [7:0] idx,
                                               logic [7:0] r, logic [7:0] g,
                                               logic [7:0] b);
    px_result_t res;
    int         n;
    int         d;
    int         best_d;
    int         dr;
    int         dg;
    int         db;
    res = '0;
    n = eff_size();
    case (act)
      ACT_WRITE: begin
        if (idx < n) pal_mirror[idx] = {r, g, b};
        else res.status = STATUS_RANGE;
      end
      ACT_CONVERT: begin
        res.argb = (idx < n) ? {ALPHA_OPAQUE, pal_mirror[idx]} : {ALPHA_OPAQUE, 24'h0};
      end
      ACT_MATCH: begin
        best_d = 0;
        for (int i = 0; i < n; i++) begin
          dr = int'(pal_mirror[i][23:16]) - int'(r);
          dg = int'(pal_mirror[i][15:8]) - int'(g);
          db = int'(pal_mirror[i][7:0]) - int'(b);
          d  = dr * dr + dg * dg + db * db;
          if (i == 0 || d < best_d) begin
            best_d  = d;
            res.idx = i[7:0];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (err_count < MAX_PRINTS)
      $display("mismatch %s on transaction %0d: expected %h got %h",
               what, result_count, want, got);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    px_result_t want;
    if (!rst && done) begin
      if (pending_px.size() == 0) begin
        report_mismatch("unexpected result", 32'h0, {31'h0, done});
      end else begin
        want = pending_px.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(status));
        if (argb_pixel !== want.argb) report_mismatch("argb_pixel", want.argb, argb_pixel);
        if (match_index !== want.idx)
          report_mismatch("match_index", 32'(want.idx), 32'(match_index));
      end
      result_count++;
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Called right after an edge; start left high, so the caller must send again
  // or drop start in the same step.
  task automatic send_item(logic [1:0] act, logic [7:0] idx, logic [7:0] r,
                           logic [7:0] g, logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    action      <= act;
    entry_index <= idx;
    red         <= r;
    green       <= g;
    blue        <= b;
    do @(posedge clk); while (busy);
    pending_px.push_back(predict_pixel(act, idx, r, g, b));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
  endtask

  task automatic set_palette_size(logic [SIZE_W-1:0] sz);
    drain();
    repeat (2) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= sz;
    @(posedge clk);
    cfg_we <= 1'b0;
    pal_size_mirror = sz;
  endtask

  function automatic logic [7:0] nudge(logic [7:0] v, int amt);
    int t;
    t = int'(v) + $urandom_range(0, 2 * amt) - amt;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  task automatic test_reset_state();
    send_item(ACT_CONVERT, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(ACT_CONVERT, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    send_item(ACT_MATCH, 8'd0, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_write_convert();
    send_item(ACT_WRITE, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    send_item(ACT_WRITE, 8'd255, 8'h12, 8'h34, 8'h56);
    send_item(ACT_WRITE, 8'd5, 8'hFF, 8'h00, 8'h80);
    send_item(ACT_CONVERT, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(ACT_CONVERT, 8'd255, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_match_ties();
    send_item(ACT_MATCH, 8'd0, 8'hFF, 8'hFF, 8'hFF);
    send_item(ACT_MATCH, 8'd0, 8'hFA, 8'h05, 8'h82);
    send_item(ACT_WRITE, 8'd7, 8'hFF, 8'h00, 8'h80);
    send_item(ACT_MATCH, 8'd0, 8'hFF, 8'h00, 8'h80);
  endtask

  task automatic test_unused_action();
    send_item(ACT_UNUSED, 8'd3, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_size_limits();
    set_palette_size(9'd6);
    send_item(ACT_WRITE, 8'd6, 8'h01, 8'h02, 8'h03);
    send_item(ACT_WRITE, 8'd255, 8'h01, 8'h02, 8'h03);
    send_item(ACT_CONVERT, 8'd255, 8'h00, 8'h00, 8'h00);
    send_item(ACT_CONVERT, 8'd5, 8'h00, 8'h00, 8'h00);
    send_item(ACT_MATCH, 8'd0, 8'h12, 8'h34, 8'h56);
    set_palette_size(9'd0);
    send_item(ACT_WRITE, 8'd0, 8'hAA, 8'h55, 8'hAA);
    send_item(ACT_CONVERT, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(ACT_MATCH, 8'd0, 8'h80, 8'h80, 8'h80);
    set_palette_size(9'd511);
    send_item(ACT_CONVERT, 8'd255, 8'h00, 8'h00, 8'h00);
    send_item(ACT_WRITE, 8'd255, 8'h00, 8'hFF, 8'h00);
    set_palette_size(9'd1);
    send_item(ACT_MATCH, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(ACT_WRITE, 8'd1, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic random_phase(logic [SIZE_W-1:0] sz, int count);
    int          eff;
    int          sel;
    int          amt;
    logic [1:0]  act;
    logic [7:0]  idx;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [23:0] c;
    set_palette_size(sz);
    eff = eff_size();
    for (int k = 0; k < count; k++) begin
      if (k % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 36) act = ACT_WRITE;
      else if (sel < 70) act = ACT_CONVERT;
      else if (sel < 97) act = ACT_MATCH;
      else act = ACT_UNUSED;
      idx = (eff == 0 || $urandom_range(0, 6) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, eff - 1));
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      // reuse a stored color: exact copies make ties, small offsets near misses
      if (eff != 0 && act != ACT_CONVERT && $urandom_range(0, 1) == 1) begin
        c   = pal_mirror[$urandom_range(0, eff - 1)];
        amt = ($urandom_range(0, 2) == 0) ? 0 : 6;
        r   = nudge(c[23:16], amt);
        g   = nudge(c[15:8], amt);
        b   = nudge(c[7:0], amt);
      end
      send_item(act, idx, r, g, b);
      if (k == count / 2 || $urandom_range(0, 99) == 0) drain();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    random_phase(9'd256, 250);
    random_phase(9'd16, 300);
    random_phase(9'd1, 80);
    random_phase(9'd2, 80);
    random_phase(9'd300, 120);
    random_phase(9'd0, 60);
    random_phase(9'd511, 100);
    random_phase(9'd40, 300);
    random_phase(9'd255, 110);
  endtask

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    action      <= ACT_WRITE;
    entry_index <= '0;
    red         <= '0;
    green       <= '0;
    blue        <= '0;
    cfg_we      <= 1'b0;
    cfg_data    <= '0;
    err_count       = 0;
    result_count    = 0;
    no_idle         = 1'b0;
    pal_size_mirror = SIZE_RESET;
    for (int i = 0; i < PALETTE_DEPTH; i++) pal_mirror[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_write_convert();
    test_match_ties();
    test_unused_action();
    test_size_limits();
    test_random_traffic();
    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/plm_pkg.sv
sv/plm_ram.sv
sv/plm_match.sv
sv/palette_lookup_and_match.sv
sv/plm_checker.sv
dv/tb_top.sv
